[rtl/bchd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchd_pkg
// shared types and constants for the button click / hold detector
// ----------------------------------------------------------------------------
package bchd_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned THR_W  = 16;
    localparam int unsigned IDX_W  = 2;

    // event codes on the result beat
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_CLICK  = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_HOLD   = 3'd3,
        EV_LONG   = 3'd4
    } event_t;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_DC_GAP   = 2'd1,
        REG_HOLD     = 2'd2,
        REG_LONG     = 2'd3
    } reg_idx_t;

    localparam logic [THR_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [THR_W-1:0] DC_GAP_RST   = 16'd250;
    localparam logic [THR_W-1:0] HOLD_RST     = 16'd1000;
    localparam logic [THR_W-1:0] LONG_RST     = 16'd3000;

    typedef struct packed {
        logic [THR_W-1:0] debounce_ms;
        logic [THR_W-1:0] double_click_gap_ms;
        logic [THR_W-1:0] hold_ms;
        logic [THR_W-1:0] long_hold_ms;
    } cfg_t;

endpackage

[rtl/bchd_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchd_cfg_regs
// threshold registers written through the configuration channel
// ----------------------------------------------------------------------------
module bchd_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [bchd_pkg::IDX_W-1:0]  wr_index,
    input  logic [bchd_pkg::THR_W-1:0]  wr_data,
    output bchd_pkg::cfg_t              cfg
);

    bchd_pkg::cfg_t cfg_reg;
    bchd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (bchd_pkg::reg_idx_t'(wr_index))
                bchd_pkg::REG_DEBOUNCE: cfg_next.debounce_ms         = wr_data;
                bchd_pkg::REG_DC_GAP:   cfg_next.double_click_gap_ms = wr_data;
                bchd_pkg::REG_HOLD:     cfg_next.hold_ms             = wr_data;
                bchd_pkg::REG_LONG:     cfg_next.long_hold_ms        = wr_data;
                default:                cfg_next                     = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms         <= bchd_pkg::DEBOUNCE_RST;
            cfg_reg.double_click_gap_ms <= bchd_pkg::DC_GAP_RST;
            cfg_reg.hold_ms             <= bchd_pkg::HOLD_RST;
            cfg_reg.long_hold_ms        <= bchd_pkg::LONG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/bchd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchd_core
// detector state and the per-sample event decision
// ----------------------------------------------------------------------------
module bchd_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic                        level,
    input  logic [bchd_pkg::TIME_W-1:0] now,
    input  bchd_pkg::cfg_t              cfg,
    output bchd_pkg::event_t            ev
);

    logic                        last_level_reg,     last_level_next;
    logic [bchd_pkg::TIME_W-1:0] press_time_reg,     press_time_next;
    logic [bchd_pkg::TIME_W-1:0] release_time_reg,   release_time_next;
    logic                        dc_waiting_reg,     dc_waiting_next;
    logic                        dc_on_release_reg,  dc_on_release_next;
    logic                        single_allowed_reg, single_allowed_next;
    logic                        ignore_release_reg, ignore_release_next;
    logic                        hold_done_reg,      hold_done_next;
    logic                        long_hold_done_reg, long_hold_done_next;

    logic [bchd_pkg::TIME_W-1:0] since_rel;
    logic [bchd_pkg::TIME_W-1:0] since_press;
    logic [bchd_pkg::TIME_W-1:0] since_rel_new;
    logic [bchd_pkg::TIME_W-1:0] since_press_new;
    logic                        rise;
    logic                        fall;

    assign since_rel   = now - release_time_reg;
    assign since_press = now - press_time_reg;
    assign rise = level && !last_level_reg
                  && (since_rel >= {16'd0, cfg.debounce_ms});
    assign fall = !level && last_level_reg
                  && (since_press >= {16'd0, cfg.debounce_ms});

    always_comb
    begin
        ev                  = bchd_pkg::EV_NONE;
        last_level_next     = level;
        press_time_next     = press_time_reg;
        release_time_next   = release_time_reg;
        dc_waiting_next     = dc_waiting_reg;
        dc_on_release_next  = dc_on_release_reg;
        single_allowed_next = single_allowed_reg;
        ignore_release_next = ignore_release_reg;
        hold_done_next      = hold_done_reg;
        long_hold_done_next = long_hold_done_reg;

        // edge rule
        if (rise)
        begin
            press_time_next     = now;
            ignore_release_next = 1'b0;
            single_allowed_next = 1'b1;
            hold_done_next      = 1'b0;
            long_hold_done_next = 1'b0;
            dc_on_release_next  = (since_rel < {16'd0, cfg.double_click_gap_ms})
                                  && !dc_on_release_reg && dc_waiting_reg;
            dc_waiting_next     = 1'b0;
        end
        else if (fall && !ignore_release_reg)
        begin
            release_time_next = now;
            if (!dc_on_release_reg)
            begin
                dc_waiting_next = 1'b1;
            end
            else
            begin
                ev                  = bchd_pkg::EV_DOUBLE;
                dc_on_release_next  = 1'b0;
                dc_waiting_next     = 1'b0;
                single_allowed_next = 1'b0;
            end
        end

        // stamps as seen after the edge rule
        since_rel_new   = now - release_time_next;
        since_press_new = now - press_time_next;

        // single click once the gap has run out
        if (!level && (since_rel_new >= {16'd0, cfg.double_click_gap_ms})
            && dc_waiting_next && !dc_on_release_next && single_allowed_next
            && (ev != bchd_pkg::EV_DOUBLE))
        begin
            ev              = bchd_pkg::EV_CLICK;
            dc_waiting_next = 1'b0;
        end

        // hold and long hold
        if (level && (since_press_new >= {16'd0, cfg.hold_ms}))
        begin
            if (!hold_done_next)
            begin
                ev                  = bchd_pkg::EV_HOLD;
                ignore_release_next = 1'b1;
                dc_on_release_next  = 1'b0;
                dc_waiting_next     = 1'b0;
                hold_done_next      = 1'b1;
            end
            if ((since_press_new >= {16'd0, cfg.long_hold_ms}) && !long_hold_done_next)
            begin
                ev                  = bchd_pkg::EV_LONG;
                long_hold_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg     <= 1'b0;
            press_time_reg     <= '0;
            release_time_reg   <= '0;
            dc_waiting_reg     <= 1'b0;
            dc_on_release_reg  <= 1'b0;
            single_allowed_reg <= 1'b1;
            ignore_release_reg <= 1'b0;
            hold_done_reg      <= 1'b0;
            long_hold_done_reg <= 1'b0;
        end
        else if (fire)
        begin
            last_level_reg     <= last_level_next;
            press_time_reg     <= press_time_next;
            release_time_reg   <= release_time_next;
            dc_waiting_reg     <= dc_waiting_next;
            dc_on_release_reg  <= dc_on_release_next;
            single_allowed_reg <= single_allowed_next;
            ignore_release_reg <= ignore_release_next;
            hold_done_reg      <= hold_done_next;
            long_hold_done_reg <= long_hold_done_next;
        end
    end

endmodule

[rtl/button_click_hold_detector.sv]
`timescale 1ns / 1ps
// path: an accepted input beat passes through the input register, then the result register
// throughput: one sample per cycle when the event channel does not stall, set by the state update in the core
// the input register refills in the same cycle its sample moves to the result register
// reset: asynchronous active-low; pipeline empties, thresholds return to 20/250/1000/3000
// ms, detector state returns to released with single click allowed
// ----------------------------------------------------------------------------
// button_click_hold_detector
// click, double click, hold and long hold events from timestamped button samples
// ----------------------------------------------------------------------------
module button_click_hold_detector
(
    input  logic                         clk,
    input  logic                         rst_n,
    // sample channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         button,
    input  logic [bchd_pkg::TIME_W-1:0]  now_ms,
    // event channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   event_res,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bchd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [bchd_pkg::THR_W-1:0]   cfg_data
);

    bchd_pkg::cfg_t              cfg;
    bchd_pkg::event_t            core_ev;

    // input register: one sample beat
    logic                        s1_valid_reg, s1_valid_next;
    logic                        button_reg;
    logic [bchd_pkg::TIME_W-1:0] now_reg;

    // result register: one event beat
    logic                        out_valid_reg, out_valid_next;
    bchd_pkg::event_t            event_reg;

    logic                        out_free;
    logic                        s1_fire;
    logic                        in_fire;

    // result register can take a new beat when empty or draining this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // sample in the input register is evaluated and its state committed
    assign s1_fire  = s1_valid_reg && out_free;
    // input register is free when empty or moving on this cycle
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    bchd_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // detector state advances only when a sample leaves the input register
    bchd_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_fire),
        .level (button_reg),
        .now   (now_reg),
        .cfg   (cfg),
        .ev    (core_ev)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            button_reg <= button;
            now_reg    <= now_ms;
        end
        if (s1_fire)
        begin
            event_reg <= core_ev;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;

    // a new sample only lands when the held one is leaving or the stage is empty
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!s1_valid_reg || s1_fire))
        else $error("input register overwritten");

    // every evaluated sample produces a result beat next cycle
    a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("evaluated sample lost its result");

    // a stalled result blocks evaluation, so no state commits behind it
    a_stall_blocks_core: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !s1_fire)
        else $error("core advanced while result stalled");

endmodule
